// ----- rtl/core/ctlb_pkg.sv -----
package ctlb_pkg;

	// sizing
	localparam int CAPACITY_DEF = 64;
	localparam int CHAR_W       = 8;
	localparam int LEN_W        = 7;

	// command codes
	localparam logic [3:0] ACT_NEXT       = 4'd0;
	localparam logic [3:0] ACT_PREV       = 4'd1;
	localparam logic [3:0] ACT_FIRST      = 4'd2;
	localparam logic [3:0] ACT_LAST       = 4'd3;
	localparam logic [3:0] ACT_INS_AFTER  = 4'd4;
	localparam logic [3:0] ACT_INS_BEFORE = 4'd5;
	localparam logic [3:0] ACT_DELETE     = 4'd6;
	localparam logic [3:0] ACT_ERASE      = 4'd7;
	localparam logic [3:0] ACT_DUMP       = 4'd8;

	// response status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic [3:0]        action;
		logic [CHAR_W-1:0] char_in;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CHAR_W-1:0] char_out;
		logic              at_cursor;
		logic              last_item;
		logic [LEN_W-1:0]  length;
	} rsp_t;

	// operation on one stack of cells
	typedef enum logic [2:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP,
		STK_REPL,
		STK_CLEAR
	} stk_op_t;

	// what one cell loads on the next edge
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_TAKE_ABOVE,
		CELL_TAKE_BELOW
	} cell_op_t;

endpackage

// ----- rtl/core/ctlb_cell.sv -----
module ctlb_cell (
	input  logic                        clk,
	input  ctlb_pkg::cell_op_t          op,
	input  logic [ctlb_pkg::CHAR_W-1:0] from_above,
	input  logic [ctlb_pkg::CHAR_W-1:0] from_below,
	output logic [ctlb_pkg::CHAR_W-1:0] q
);

	logic [ctlb_pkg::CHAR_W-1:0] char_q;

	// one character slot, shifted toward either neighbor
	always_ff @(posedge clk) begin
		case (op)
			ctlb_pkg::CELL_TAKE_ABOVE: char_q <= from_above;
			ctlb_pkg::CELL_TAKE_BELOW: char_q <= from_below;
			default:                   char_q <= char_q;
		endcase
	end

	assign q = char_q;

endmodule

// ----- rtl/core/ctlb_stack.sv -----
module ctlb_stack #(
	parameter int DEPTH = ctlb_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctlb_pkg::stk_op_t             op,
	input  logic [ctlb_pkg::CHAR_W-1:0]   din,
	output logic [ctlb_pkg::CHAR_W-1:0]   top,
	output logic [$clog2(DEPTH+1)-1:0]    count
);

	localparam int CW = $clog2(DEPTH+1);

	logic [ctlb_pkg::CHAR_W-1:0] cell_q [DEPTH];
	ctlb_pkg::cell_op_t          cell_op [DEPTH];
	logic [CW-1:0]               count_q;

	// row of cells, top of stack at cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ctlb_pkg::CHAR_W-1:0] above;
		logic [ctlb_pkg::CHAR_W-1:0] below;

		if (i == 0) begin : g_top
			assign above = din;
		end else begin : g_mid
			assign above = cell_q[i-1];
		end

		if (i == DEPTH-1) begin : g_bot
			assign below = cell_q[i];
		end else begin : g_nbot
			assign below = cell_q[i+1];
		end

		// per-cell shift decision
		always_comb begin
			case (op)
				ctlb_pkg::STK_PUSH: cell_op[i] = ctlb_pkg::CELL_TAKE_ABOVE;
				ctlb_pkg::STK_POP:  cell_op[i] = ctlb_pkg::CELL_TAKE_BELOW;
				ctlb_pkg::STK_REPL: cell_op[i] = (i == 0) ? ctlb_pkg::CELL_TAKE_ABOVE
				                                          : ctlb_pkg::CELL_HOLD;
				default:            cell_op[i] = ctlb_pkg::CELL_HOLD;
			endcase
		end

		ctlb_cell u_cell (
			.clk        (clk),
			.op         (cell_op[i]),
			.from_above (above),
			.from_below (below),
			.q          (cell_q[i])
		);
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				ctlb_pkg::STK_PUSH:  count_q <= count_q + CW'(1);
				ctlb_pkg::STK_POP:   count_q <= count_q - CW'(1);
				ctlb_pkg::STK_CLEAR: count_q <= '0;
				default:             count_q <= count_q;
			endcase
		end
	end

	assign top   = cell_q[0];
	assign count = count_q;

endmodule

// ----- rtl/core/cursor_text_line_buffer.sv -----
// Next, prev, insert, delete, erase: the stacks shift as the request is taken, then
// S_RESP loads the response. First and last: S_FIRST or S_LAST walks the cursor before S_RESP.
// Dump: S_REWIND walks the cursor to the head, S_STREAM sends one character per cycle
// while the output is not stalled, then S_RESTORE walks the cursor back to its index.
// A new request is taken only in S_IDLE, after the previous one has finished.
// Reset: counts and control clear at once (empty line); character cells are not reset.
module cursor_text_line_buffer #(
	parameter int CAPACITY = ctlb_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  ctlb_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ctlb_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY+1);
	localparam int IW = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_FIRST,
		S_LAST,
		S_REWIND,
		S_STREAM,
		S_RESTORE
	} state_t;

	state_t                      state_q;
	logic                        rsp_valid_q;
	ctlb_pkg::rsp_t              rsp_q;
	logic [1:0]                  sts_q;
	logic [IW-1:0]               idx_q;
	logic [IW-1:0]               pos_q;

	ctlb_pkg::stk_op_t           l_op;
	ctlb_pkg::stk_op_t           r_op;
	logic [ctlb_pkg::CHAR_W-1:0] l_din;
	logic [ctlb_pkg::CHAR_W-1:0] r_din;
	logic [ctlb_pkg::CHAR_W-1:0] l_top;
	logic [ctlb_pkg::CHAR_W-1:0] r_top;
	logic [CW-1:0]               l_cnt;
	logic [CW-1:0]               r_cnt;
	logic [CW-1:0]               total;
	logic                        full;
	logic                        is_ins;
	logic                        accept;
	logic                        out_free;
	logic                        rsp_load;

	// left stack: characters before the cursor, nearest on top
	ctlb_stack #(.DEPTH(CAPACITY)) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (l_op),
		.din    (l_din),
		.top    (l_top),
		.count  (l_cnt)
	);

	// right stack: cursor character on top, then the rest of the line
	ctlb_stack #(.DEPTH(CAPACITY)) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (r_op),
		.din    (r_din),
		.top    (r_top),
		.count  (r_cnt)
	);

	assign total     = CW'(l_cnt + r_cnt);
	assign full      = (total == CW'(CAPACITY));
	assign is_ins    = (cmd.action == ctlb_pkg::ACT_INS_AFTER) ||
	                   (cmd.action == ctlb_pkg::ACT_INS_BEFORE);
	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = ((state_q == S_RESP) || (state_q == S_STREAM)) && out_free;

	// stack operations for the current step
	always_comb begin
		l_op  = ctlb_pkg::STK_HOLD;
		r_op  = ctlb_pkg::STK_HOLD;
		l_din = r_top;
		r_din = l_top;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.action)
						ctlb_pkg::ACT_NEXT: begin
							if (r_cnt > CW'(1)) begin
								r_op = ctlb_pkg::STK_POP;
								l_op = ctlb_pkg::STK_PUSH;
							end
						end
						ctlb_pkg::ACT_PREV: begin
							if (l_cnt != '0) begin
								l_op = ctlb_pkg::STK_POP;
								r_op = ctlb_pkg::STK_PUSH;
							end
						end
						ctlb_pkg::ACT_INS_AFTER: begin
							r_din = cmd.char_in;
							if (!full) begin
								if (total == '0) begin
									r_op = ctlb_pkg::STK_PUSH;
								end else begin
									l_op = ctlb_pkg::STK_PUSH;
									r_op = ctlb_pkg::STK_REPL;
								end
							end
						end
						ctlb_pkg::ACT_INS_BEFORE: begin
							r_din = cmd.char_in;
							if (!full) begin
								r_op = ctlb_pkg::STK_PUSH;
							end
						end
						ctlb_pkg::ACT_DELETE: begin
							if (total != '0) begin
								if (l_cnt == '0) begin
									r_op = ctlb_pkg::STK_POP;
								end else begin
									r_op = ctlb_pkg::STK_REPL;
									l_op = ctlb_pkg::STK_POP;
								end
							end
						end
						ctlb_pkg::ACT_ERASE: begin
							l_op = ctlb_pkg::STK_CLEAR;
							r_op = ctlb_pkg::STK_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			S_FIRST, S_REWIND: begin
				if (l_cnt != '0) begin
					l_op = ctlb_pkg::STK_POP;
					r_op = ctlb_pkg::STK_PUSH;
				end
			end
			S_LAST: begin
				if (r_cnt > CW'(1)) begin
					r_op = ctlb_pkg::STK_POP;
					l_op = ctlb_pkg::STK_PUSH;
				end
			end
			S_STREAM: begin
				if (out_free) begin
					r_op = ctlb_pkg::STK_POP;
					l_op = ctlb_pkg::STK_PUSH;
				end
			end
			S_RESTORE: begin
				if (l_cnt != CW'(idx_q)) begin
					l_op = ctlb_pkg::STK_POP;
					r_op = ctlb_pkg::STK_PUSH;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			sts_q       <= ctlb_pkg::STS_OK;
			idx_q       <= '0;
			pos_q       <= '0;
		end else begin
			// load a new response or drop the one taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sts_q <= (is_ins && full) ? ctlb_pkg::STS_FULL : ctlb_pkg::STS_OK;
						case (cmd.action)
							ctlb_pkg::ACT_FIRST: state_q <= S_FIRST;
							ctlb_pkg::ACT_LAST:  state_q <= S_LAST;
							ctlb_pkg::ACT_DUMP: begin
								idx_q <= l_cnt[IW-1:0];
								pos_q <= '0;
								state_q <= (total == '0) ? S_RESP : S_REWIND;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						rsp_q.at_cursor <= 1'b0;
						rsp_q.last_item <= 1'b1;
						rsp_q.length    <= ctlb_pkg::LEN_W'(total);
						if (total == '0) begin
							rsp_q.status   <= (sts_q == ctlb_pkg::STS_FULL) ?
							                  ctlb_pkg::STS_FULL : ctlb_pkg::STS_EMPTY;
							rsp_q.char_out <= '0;
						end else begin
							rsp_q.status   <= sts_q;
							rsp_q.char_out <= r_top;
						end
						state_q <= S_IDLE;
					end
				end
				S_FIRST: begin
					if (l_cnt == '0) begin
						state_q <= S_RESP;
					end
				end
				S_LAST: begin
					if (r_cnt <= CW'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_REWIND: begin
					if (l_cnt == '0) begin
						state_q <= S_STREAM;
					end
				end
				S_STREAM: begin
					if (out_free) begin
						rsp_q.status    <= ctlb_pkg::STS_OK;
						rsp_q.char_out  <= r_top;
						rsp_q.at_cursor <= (pos_q == idx_q);
						rsp_q.last_item <= (r_cnt == CW'(1));
						rsp_q.length    <= ctlb_pkg::LEN_W'(total);
						pos_q           <= pos_q + IW'(1);
						if (r_cnt == CW'(1)) begin
							state_q <= S_RESTORE;
						end
					end
				end
				S_RESTORE: begin
					if (l_cnt == CW'(idx_q)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// line never grows past capacity
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total <= CW'(CAPACITY))
		else $error("line length above capacity");

	// a non-empty line has a character under the cursor outside the dump restore walk
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != S_RESTORE) && (total != '0)) |-> (r_cnt != '0))
		else $error("cursor stack empty on non-empty line");

	// an accepted request always starts work
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("request accepted without leaving idle");

	// cursor walks never change the length
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(total))
		else $error("length changed during cursor walk");

endmodule

// ----- tb/cursor_text_line_buffer_checker.sv -----
module cursor_text_line_buffer_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_stall,
	input  ctlb_pkg::cmd_t cmd,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  ctlb_pkg::rsp_t rsp,
	output int             mismatches,
	output int             rsp_outstanding
);
	import ctlb_pkg::*;

	localparam int LINE_CAP = CAPACITY_DEF;

	// shadow of the text line: bytes in order, cursor as an index
	logic [CHAR_W-1:0] line_bytes [$];
	int                cursor_idx;
	rsp_t              rsp_due [$];

	initial begin
		mismatches      = 0;
		rsp_outstanding = 0;
		cursor_idx      = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 60)
			$display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// single response for every request but a dump of a non-empty line
	function automatic rsp_t cursor_rsp(input logic [1:0] st);
		rsp_t r;
		r           = '0;
		r.last_item = 1'b1;
		r.length    = LEN_W'(line_bytes.size());
		if (line_bytes.size() == 0) begin
			r.status = (st == STS_FULL) ? STS_FULL : STS_EMPTY;
		end else begin
			r.status   = st;
			r.char_out = line_bytes[cursor_idx];
		end
		return r;
	endfunction

	// apply one request to the shadow line and queue what it must produce
	task automatic apply_line_cmd(input cmd_t c);
		rsp_t       r;
		logic [1:0] st;
		int         n;
		int         i;
		n  = line_bytes.size();
		st = STS_OK;
		if (c.action == ACT_DUMP) begin
			if (n == 0) begin
				rsp_due.push_back(cursor_rsp(STS_OK));
			end else begin
				for (i = 0; i < n; i++) begin
					r           = '0;
					r.status    = STS_OK;
					r.char_out  = line_bytes[i];
					r.at_cursor = (i == cursor_idx);
					r.last_item = (i == n - 1);
					r.length    = LEN_W'(n);
					rsp_due.push_back(r);
				end
			end
		end else begin
			case (c.action)
			ACT_NEXT: begin
				if (n != 0 && cursor_idx < n - 1) cursor_idx++;
			end
			ACT_PREV: begin
				if (cursor_idx > 0) cursor_idx--;
			end
			ACT_FIRST: begin
				cursor_idx = 0;
			end
			ACT_LAST: begin
				if (n != 0) cursor_idx = n - 1;
			end
			ACT_INS_AFTER, ACT_INS_BEFORE: begin
				if (n >= LINE_CAP) begin
					st = STS_FULL;
				end else if (n == 0) begin
					line_bytes.push_back(c.char_in);
					cursor_idx = 0;
				end else begin
					// cursor lands on the new byte either way
					if (c.action == ACT_INS_AFTER) cursor_idx++;
					if (cursor_idx == n) line_bytes.push_back(c.char_in);
					else line_bytes.insert(cursor_idx, c.char_in);
				end
			end
			ACT_DELETE: begin
				// removing the head leaves the cursor on the new head
				if (n != 0) begin
					line_bytes.delete(cursor_idx);
					if (cursor_idx > 0) cursor_idx--;
				end
			end
			ACT_ERASE: begin
				line_bytes.delete();
				cursor_idx = 0;
			end
			default: begin
			end
			endcase
			rsp_due.push_back(cursor_rsp(st));
		end
	endtask

	// compare first: a response at this edge never belongs to a request taken now
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					report_mismatch("response with nothing outstanding, char_out",
						rsp.char_out, 0);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status != want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.char_out != want.char_out)
						report_mismatch("char_out", rsp.char_out, want.char_out);
					if (rsp.at_cursor != want.at_cursor)
						report_mismatch("at_cursor", rsp.at_cursor, want.at_cursor);
					if (rsp.last_item != want.last_item)
						report_mismatch("last_item", rsp.last_item, want.last_item);
					if (rsp.length != want.length)
						report_mismatch("length", rsp.length, want.length);
				end
			end
			if (cmd_valid && !cmd_stall) apply_line_cmd(cmd);
			rsp_outstanding = rsp_due.size();
		end
	end

endmodule

// ----- tb/cursor_text_line_buffer_test.sv -----
module cursor_text_line_buffer_test;
	import ctlb_pkg::*;

	localparam int LINE_CAP        = CAPACITY_DEF;
	localparam int TOTAL_ITEMS     = 500;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT  = 5000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int mismatches;
	int rsp_outstanding;
	int sent_count    = 0;
	int idle_cycles   = 0;
	bit hold_off_due  = 1'b0;
	bit steady_sender = 1'b0;

	cursor_text_line_buffer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	cursor_text_line_buffer_checker line_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.cmd             (cmd),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.mismatches      (mismatches),
		.rsp_outstanding (rsp_outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// give up when neither channel moves for too long
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [CHAR_W-1:0] any_byte();
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (steady_sender) return 0;
		r = $urandom_range(0, 19);
		if (r < 11) return 0;
		if (r < 17) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 9);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [3:0] pick_move();
		case ($urandom_range(0, 3))
		0: return ACT_NEXT;
		1: return ACT_PREV;
		2: return ACT_FIRST;
		default: return ACT_LAST;
		endcase
	endfunction

	function automatic logic [3:0] pick_insert();
		return $urandom_range(0, 1) ? ACT_INS_AFTER : ACT_INS_BEFORE;
	endfunction

	function automatic logic [3:0] pick_edit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38) return pick_insert();
		if (r < 62) return pick_move();
		if (r < 80) return ACT_DELETE;
		if (r < 90) return ACT_DUMP;
		if (r < 92) return ACT_ERASE;
		return 4'($urandom_range(int'(ACT_DUMP) + 1, 15));
	endfunction

	// one request: payload set at the falling edge, held until taken
	task automatic send_cmd(input logic [3:0] act, input logic [CHAR_W-1:0] ch);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= '{action: act, char_in: ch};
		do @(posedge clk); while (cmd_stall);
		sent_count++;
	endtask

	// start from nothing and insert past capacity, moving now and then
	task automatic fill_line();
		int k;
		send_cmd(ACT_ERASE, any_byte());
		for (k = 0; k < LINE_CAP + 4; k++) begin
			if ($urandom_range(0, 5) == 0) send_cmd(pick_move(), any_byte());
			send_cmd(pick_insert(), any_byte());
		end
		send_cmd(ACT_DUMP, any_byte());
	endtask

	// delete-heavy run that shortens the line, with a move now and then
	task automatic drain_line();
		int k;
		for (k = 0; k < 40; k++) begin
			if ($urandom_range(0, 3) == 0) send_cmd(pick_move(), any_byte());
			else send_cmd(ACT_DELETE, any_byte());
		end
		send_cmd(ACT_DUMP, any_byte());
	endtask

	// receiver side: random stalls, idle-free stretches, one long hold-off
	initial begin
		bit hold_off_done;
		int pick;
		int span;
		hold_off_done = 1'b0;
		rsp_stall     = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_due && !hold_off_done) begin
				hold_off_done = 1'b1;
				rsp_stall <= 1'b1;
				span = HOLD_OFF_CYCLES;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 10) begin
					rsp_stall <= 1'b0;
					span = $urandom_range(1, 6);
				end else if (pick < 13) begin
					rsp_stall <= 1'b0;
					span = $urandom_range(20, 80);
				end else if (pick < 19) begin
					rsp_stall <= 1'b1;
					span = $urandom_range(1, 3);
				end else begin
					rsp_stall <= 1'b1;
					span = $urandom_range(10, 40);
				end
			end
			repeat (span) @(negedge clk);
		end
	end

	// sender side and verdict
	initial begin
		int pick;
		int k;
		int n;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// requests on an empty line
		send_cmd(ACT_NEXT, any_byte());
		send_cmd(ACT_PREV, any_byte());
		send_cmd(ACT_FIRST, any_byte());
		send_cmd(ACT_LAST, any_byte());
		send_cmd(ACT_DELETE, any_byte());
		send_cmd(ACT_DUMP, any_byte());
		send_cmd(4'hF, any_byte());
		// build a short line at both ends and in the middle
		send_cmd(ACT_INS_AFTER, 8'h00);
		send_cmd(ACT_INS_BEFORE, 8'hFF);
		send_cmd(ACT_INS_AFTER, 8'hA5);
		send_cmd(ACT_INS_BEFORE, 8'h5A);
		send_cmd(ACT_DUMP, any_byte());
		// moves, including past either end
		send_cmd(ACT_NEXT, any_byte());
		send_cmd(ACT_NEXT, any_byte());
		send_cmd(ACT_NEXT, any_byte());
		send_cmd(ACT_FIRST, any_byte());
		send_cmd(ACT_PREV, any_byte());
		// delete the head, then the tail, then an unused code
		send_cmd(ACT_DELETE, any_byte());
		send_cmd(ACT_LAST, any_byte());
		send_cmd(ACT_DELETE, any_byte());
		send_cmd(4'h9, any_byte());
		send_cmd(ACT_DUMP, any_byte());
		// erase, then a single byte inserted and deleted
		send_cmd(ACT_ERASE, any_byte());
		send_cmd(ACT_INS_BEFORE, 8'h81);
		send_cmd(ACT_DELETE, any_byte());
		send_cmd(ACT_DUMP, any_byte());

		// fill past capacity while the receiver holds off
		hold_off_due = 1'b1;
		fill_line();

		while (sent_count < TOTAL_ITEMS) begin
			steady_sender = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				n = $urandom_range(10, 40);
				for (k = 0; k < n; k++) send_cmd(pick_edit(), any_byte());
			end else if (pick < 9) begin
				drain_line();
			end else begin
				fill_line();
			end
		end
		steady_sender = 1'b0;

		@(negedge clk);
		cmd_valid <= 1'b0;
		wait (rsp_outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && rsp_outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ctlb_pkg.sv
rtl/core/ctlb_cell.sv
rtl/core/ctlb_stack.sv
rtl/core/cursor_text_line_buffer.sv
tb/cursor_text_line_buffer_checker.sv
tb/cursor_text_line_buffer_test.sv
